>>> hdl/dtcf_pkg.sv
`timescale 1ns / 1ps

package dtcf_pkg;

    // command codes
    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_GLYPH = 3'd1;
    localparam logic [2:0] CMD_FG_BG = 3'd2;
    localparam logic [2:0] CMD_FG    = 3'd3;
    localparam logic [2:0] CMD_BG    = 3'd4;
    localparam logic [2:0] CMD_ALL   = 3'd5;
    localparam logic [2:0] CMD_READ  = 3'd6;

    // result status codes
    localparam logic [1:0] ST_WRITTEN  = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    // register indexes
    localparam logic [2:0] REG_COLS     = 3'd0;
    localparam logic [2:0] REG_ROWS     = 3'd1;
    localparam logic [2:0] REG_BLANK_G  = 3'd2;
    localparam logic [2:0] REG_BLANK_FG = 3'd3;
    localparam logic [2:0] REG_BLANK_BG = 3'd4;

    // register reset values
    localparam logic [7:0] COLS_RST     = 8'd80;
    localparam logic [5:0] ROWS_RST     = 6'd23;
    localparam logic [7:0] BLANK_G_RST  = 8'd32;
    localparam logic [7:0] BLANK_FG_RST = 8'd15;
    localparam logic [7:0] BLANK_BG_RST = 8'd0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_READ,
        OP_WRITE,
        OP_DROP
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        in_range;
        logic        set_glyph;
        logic        set_fg;
        logic        set_bg;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] depth;
        logic [7:0]  glyph;
        logic [7:0]  fg;
        logic [7:0]  bg;
        logic        use_depth;
        logic        depth_write;
    } queue_item_t;

    typedef struct packed {
        logic [7:0] glyph;
        logic [7:0] fg;
        logic [7:0] bg;
    } blank_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

>>> hdl/dtcf_front.sv
`timescale 1ns / 1ps

module dtcf_front import dtcf_pkg::*; #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,
    input  logic [7:0]   cols_in_use,
    input  logic [5:0]   rows_in_use,
    input  back_status_t back_status,
    input  logic         q_full,
    output logic         q_push,
    output queue_item_t  q_item
);

    logic [2:0] command;
    logic [7:0] col;
    logic [7:0] row;
    logic       in_range;

    assign command = s_tdata[2:0];
    assign col     = s_tdata[10:3];
    assign row     = s_tdata[18:11];

    assign in_range = (col < cols_in_use) && (row < {2'b00, rows_in_use})
                      && ({1'b0, col} < 9'(MAX_COLS)) && ({1'b0, row} < 9'(MAX_ROWS));

    assign s_tready = !q_full && !back_status.init_busy;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_item             = '0;
        q_item.in_range    = in_range;
        q_item.col         = col;
        q_item.row         = row;
        q_item.depth       = s_tdata[50:19];
        q_item.glyph       = s_tdata[58:51];
        q_item.fg          = s_tdata[66:59];
        q_item.bg          = s_tdata[74:67];
        q_item.use_depth   = s_tdata[75];
        q_item.depth_write = s_tdata[76];
        q_item.set_glyph   = 1'b0;
        q_item.set_fg      = 1'b0;
        q_item.set_bg      = 1'b0;
        case (command)
            CMD_GLYPH: q_item.set_glyph = 1'b1;
            CMD_FG_BG: begin
                q_item.set_fg = 1'b1;
                q_item.set_bg = 1'b1;
            end
            CMD_FG:    q_item.set_fg = 1'b1;
            CMD_BG:    q_item.set_bg = 1'b1;
            CMD_ALL: begin
                q_item.set_glyph = 1'b1;
                q_item.set_fg    = 1'b1;
                q_item.set_bg    = 1'b1;
            end
            default: ;
        endcase
        // the unused code behaves as a read
        if (command == CMD_CLEAR) begin
            q_item.kind = OP_CLEAR;
        end else if (command inside {[CMD_GLYPH:CMD_ALL]}) begin
            q_item.kind = in_range ? OP_WRITE : OP_DROP;
        end else begin
            q_item.kind = in_range ? OP_READ : OP_DROP;
        end
    end

endmodule

>>> hdl/dtcf_queue.sv
`timescale 1ns / 1ps

module dtcf_queue import dtcf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  queue_item_t push_item,
    output logic        full,
    input  logic        pop,
    output queue_item_t head,
    output logic        empty
);

    queue_item_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       wr_ptr_reg;
    logic [QUEUE_AW-1:0]       rd_ptr_reg;
    logic [QUEUE_AW:0]         count_reg;
    logic [QUEUE_AW:0]         count_next;

    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hdl/dtcf_back.sv
`timescale 1ns / 1ps

module dtcf_back import dtcf_pkg::*; #(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 32,
    parameter int DEPTH_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  blank_t       blank,
    input  logic         q_empty,
    input  queue_item_t  q_head,
    output logic         q_pop,
    output back_status_t back_status,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata
);

    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IW    = 18;
    localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DMAX = ~DMIN;

    typedef enum logic [1:0] {
        B_SWEEP,
        B_IDLE,
        B_READ,
        B_CLEAR_DONE
    } back_state_t;

    logic [23:0]                  cell_mem  [CELLS];
    logic signed [DEPTH_BITS-1:0] depth_mem [CELLS];

    back_state_t                  state_reg;
    logic [AW-1:0]                sweep_reg;
    logic                         report_reg;
    blank_t                       blank_reg;
    queue_item_t                  item_reg;
    logic [AW-1:0]                addr_reg;
    logic [23:0]                  rd_cell_q;
    logic signed [DEPTH_BITS-1:0] rd_depth_q;
    logic                         m_valid_reg;
    logic [1:0]                   status_reg;
    logic [7:0]                   glyph_reg;
    logic [7:0]                   fg_reg;
    logic [7:0]                   bg_reg;
    logic [31:0]                  depth_reg;

    logic [IW-1:0]                head_idx;
    logic [AW-1:0]                head_addr;
    logic                         out_free;
    logic                         res_load;
    logic                         rd_en;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [23:0]                  wr_cell;
    logic signed [DEPTH_BITS-1:0] wr_depth;
    logic signed [DEPTH_BITS-1:0] z;
    logic                         reject;
    logic [7:0]                   new_glyph;
    logic [7:0]                   new_fg;
    logic [7:0]                   new_bg;
    logic signed [DEPTH_BITS-1:0] new_depth;
    logic [1:0]                   res_status;
    logic [23:0]                  res_cell;
    logic signed [DEPTH_BITS-1:0] res_depth;
    logic [31:0]                  res_depth32;

    assign head_idx  = IW'(q_head.row) * IW'(MAX_COLS) + IW'(q_head.col);
    assign head_addr = head_idx[AW-1:0];
    assign out_free  = !m_valid_reg || m_tready;

    // a result enters the output register this cycle
    assign res_load = (state_reg == B_IDLE && q_pop && q_head.kind == OP_DROP)
                      || ((state_reg == B_READ || state_reg == B_CLEAR_DONE) && out_free);

    assign back_status.init_busy = (state_reg == B_SWEEP) && !report_reg;

    // incoming depth brought to the store width
    if (DEPTH_BITS > 32) begin : g_z_wide
        assign z = {{(DEPTH_BITS-32){item_reg.depth[31]}}, item_reg.depth};
    end else if (DEPTH_BITS == 32) begin : g_z_same
        assign z = item_reg.depth;
    end else begin : g_z_narrow
        logic fits;
        assign fits = (&item_reg.depth[31:DEPTH_BITS-1]) || !(|item_reg.depth[31:DEPTH_BITS-1]);
        assign z = fits ? item_reg.depth[DEPTH_BITS-1:0] : (item_reg.depth[31] ? DMIN : DMAX);
    end

    // stored depth brought to the 32-bit result
    if (DEPTH_BITS > 32) begin : g_o_wide
        logic fits;
        assign fits = (&res_depth[DEPTH_BITS-1:31]) || !(|res_depth[DEPTH_BITS-1:31]);
        assign res_depth32 = fits ? res_depth[31:0]
                           : (res_depth[DEPTH_BITS-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    end else if (DEPTH_BITS == 32) begin : g_o_same
        assign res_depth32 = res_depth;
    end else begin : g_o_narrow
        assign res_depth32 = {{(32-DEPTH_BITS){res_depth[DEPTH_BITS-1]}}, res_depth};
    end

    // depth test and merge
    always_comb begin
        reject    = item_reg.use_depth && (rd_depth_q > z);
        new_glyph = item_reg.set_glyph ? item_reg.glyph : rd_cell_q[23:16];
        new_fg    = item_reg.set_fg ? item_reg.fg : rd_cell_q[15:8];
        new_bg    = item_reg.set_bg ? item_reg.bg : rd_cell_q[7:0];
        new_depth = item_reg.depth_write ? z : rd_depth_q;
        if (state_reg == B_CLEAR_DONE) begin
            res_status = ST_DONE;
            res_cell   = item_reg.in_range ? {blank_reg.glyph, blank_reg.fg, blank_reg.bg} : '0;
            res_depth  = DMIN;
        end else if (item_reg.kind != OP_WRITE) begin
            res_status = ST_DONE;
            res_cell   = rd_cell_q;
            res_depth  = rd_depth_q;
        end else if (reject) begin
            res_status = ST_REJECTED;
            res_cell   = rd_cell_q;
            res_depth  = rd_depth_q;
        end else begin
            res_status = ST_WRITTEN;
            res_cell   = {new_glyph, new_fg, new_bg};
            res_depth  = new_depth;
        end
    end

    // memory port control
    always_comb begin
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = addr_reg;
        wr_cell  = res_cell;
        wr_depth = new_depth;
        case (state_reg)
            B_SWEEP: begin
                wr_en    = 1'b1;
                wr_addr  = sweep_reg;
                wr_cell  = {blank_reg.glyph, blank_reg.fg, blank_reg.bg};
                wr_depth = DMIN;
            end
            B_IDLE: begin
                if (!q_empty) begin
                    case (q_head.kind)
                        OP_CLEAR: q_pop = 1'b1;
                        OP_DROP:  q_pop = out_free;
                        default: begin
                            q_pop = 1'b1;
                            rd_en = 1'b1;
                        end
                    endcase
                end
            end
            B_READ: begin
                wr_en = out_free && (item_reg.kind == OP_WRITE) && !reject;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr]  <= wr_cell;
            depth_mem[wr_addr] <= wr_depth;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_cell_q  <= cell_mem[head_addr];
            rd_depth_q <= depth_mem[head_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_SWEEP;
            sweep_reg   <= '0;
            report_reg  <= 1'b0;
            blank_reg   <= {BLANK_G_RST, BLANK_FG_RST, BLANK_BG_RST};
            m_valid_reg <= 1'b0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_SWEEP: begin
                    if (sweep_reg == AW'(CELLS - 1)) begin
                        sweep_reg <= '0;
                        state_reg <= report_reg ? B_CLEAR_DONE : B_IDLE;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                B_IDLE: begin
                    if (q_pop) begin
                        item_reg <= q_head;
                        addr_reg <= head_addr;
                        case (q_head.kind)
                            OP_CLEAR: begin
                                blank_reg  <= blank;
                                report_reg <= 1'b1;
                                state_reg  <= B_SWEEP;
                            end
                            OP_DROP: begin
                                status_reg  <= ST_RANGE;
                                glyph_reg   <= '0;
                                fg_reg      <= '0;
                                bg_reg      <= '0;
                                depth_reg   <= '0;
                            end
                            default: state_reg <= B_READ;
                        endcase
                    end
                end
                B_READ, B_CLEAR_DONE: begin
                    if (out_free) begin
                        status_reg  <= res_status;
                        glyph_reg   <= res_cell[23:16];
                        fg_reg      <= res_cell[15:8];
                        bg_reg      <= res_cell[7:0];
                        depth_reg   <= (state_reg == B_CLEAR_DONE && !item_reg.in_range)
                                       ? 32'd0 : res_depth32;
                        state_reg   <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, depth_reg, bg_reg, fg_reg, glyph_reg, status_reg};

endmodule

>>> hdl/depth_tested_cell_framebuffer_unit.sv
`timescale 1ns / 1ps
// cell access: the back end reads the memories, then registers the result and writes
//   back a passing write; it takes no new item before the last result is registered
// clear: the back end sweeps all MAX_COLS*MAX_ROWS cells, one per cycle, then reports;
//   the front keeps queuing meanwhile until the queue is full
// reset: synchronous, active low; afterwards a clearing pass over all MAX_COLS*MAX_ROWS
//   cells (4096 at defaults) holds s_tready low, configuration writes still taken

module depth_tested_cell_framebuffer_unit import dtcf_pkg::*; #(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 32,
    parameter int DEPTH_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command transaction in
    input  logic        s_tvalid,
    output logic        s_tready,
    // command [2:0], col [10:3], row [18:11], depth [50:19], glyph [58:51],
    // fg_colour [66:59], bg_colour [74:67], use_depth [75], depth_write [76]
    input  logic [79:0] s_tdata,
    // result transaction out
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [1:0], cell_glyph [9:2], cell_fg [17:10], cell_bg [25:18],
    // cell_depth [57:26]
    output logic [63:0] m_tdata,
    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // configuration registers
    logic [7:0]   cols_reg;
    logic [5:0]   rows_reg;
    blank_t       blank_reg;

    // front to back
    queue_item_t  push_item;
    queue_item_t  head_item;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;
    back_status_t back_status;

    // writes are always taken; index values past the register list are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= COLS_RST;
            rows_reg  <= ROWS_RST;
            blank_reg <= {BLANK_G_RST, BLANK_FG_RST, BLANK_BG_RST};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COLS:     cols_reg        <= cfg_data;
                REG_ROWS:     rows_reg        <= cfg_data[5:0];
                REG_BLANK_G:  blank_reg.glyph <= cfg_data;
                REG_BLANK_FG: blank_reg.fg    <= cfg_data;
                REG_BLANK_BG: blank_reg.bg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: range check and command decode
    dtcf_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cols_in_use (cols_reg),
        .rows_in_use (rows_reg),
        .back_status (back_status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    // short queue decoupling front and back
    dtcf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head_item),
        .empty     (q_empty)
    );

    // back: cell and depth memories, depth test, clear sweep, result register
    dtcf_back #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .blank       (blank_reg),
        .q_empty     (q_empty),
        .q_head      (head_item),
        .q_pop       (q_pop),
        .back_status (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // no command is taken during the post-reset clearing pass
    a_no_accept_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.init_busy |-> !(s_tvalid && s_tready))
        else $error("command accepted during clearing pass");

    // a column count write lands in its register
    a_cols_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_index == REG_COLS) |=> (cols_reg == $past(cfg_data)))
        else $error("column count write lost");

    // out-of-range results carry an empty cell
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == ST_RANGE) |-> (m_tdata[57:2] == '0))
        else $error("out-of-range result with cell data");

endmodule
